@@ sv/bbe_pkg.sv @@
// Balanced block extent: shared types and register indexes.
// No dependencies; imported by every module of the block.
`default_nettype none
package bbe_pkg;

    // configuration register indexes
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_CELLS_X  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CELLS_Y  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CELLS_Z  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BLOCKS_X = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BLOCKS_Y = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BLOCKS_Z = 3'd5;

    localparam int unsigned NUM_AXES = 3;

    // pipeline load strobes from the merge stage to the lanes
    typedef struct packed {
        logic ld1;   // request enters the product stage
        logic ld2;   // product stage moves into the output register
    } t_pipe_ctl;

endpackage
`default_nettype wire

@@ sv/balanced_block_extent_core.sv @@
// Balanced block extent top level: configuration registers, three axis lanes
// and the merge stage. Depends on bbe_pkg, bbe_lane, bbe_div and bbe_merge.
//
// Splits a cells_x*cells_y*cells_z grid into blocks_x*blocks_y*blocks_z
// near-equal blocks and returns, for a block coordinate (i,j,k), the
// inclusive cell range on each axis and the linear index i + j*nx + k*nx*ny.
// Requests stream at one transfer per clock while s_axis_tready is high,
// through the product stage, then the output register. Each axis lane holds
// a bit-serial divider that forms cells/blocks and the remainder; any
// configuration write restarts all three, and s_axis_tready stays low from
// the write until the dividers finish. A request is
// refused (tuser set, all other fields zero) when an axis has zero blocks,
// at least as many blocks as cells, or a coordinate is not below its count.
`default_nettype none
module balanced_block_extent_core
    import bbe_pkg::*;
#(
    parameter int unsigned CELL_BITS  = 16,
    parameter int unsigned BLOCK_BITS = 10
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration write port
    input  wire logic                    i_cfg_we,
    input  wire logic [REG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [((CELL_BITS > BLOCK_BITS) ? CELL_BITS : BLOCK_BITS)-1:0] i_cfg_data,
    // request stream; tdata: block_i, block_j, block_k
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [((3*BLOCK_BITS+7)/8)*8-1:0] s_axis_tdata,
    // result stream; tdata: lo_x, hi_x, lo_y, hi_y, lo_z, hi_z, linear_index
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [((6*CELL_BITS+3*BLOCK_BITS+7)/8)*8-1:0] m_axis_tdata,
    // tuser: bad_request
    output logic [0:0]                   m_axis_tuser
);

    localparam int unsigned OUT_W  = ((6*CELL_BITS+3*BLOCK_BITS+7)/8)*8;
    localparam int unsigned FLD_W  = 6*CELL_BITS + 3*BLOCK_BITS;

    logic [NUM_AXES-1:0][CELL_BITS-1:0]  r_cells;
    logic [NUM_AXES-1:0][BLOCK_BITS-1:0] r_blocks;
    logic [2*BLOCK_BITS-1:0]             r_blocks_xy;
    logic                                r_start;

    logic [NUM_AXES-1:0][BLOCK_BITS-1:0] w_pos;
    logic [NUM_AXES-1:0]                 w_busy;
    logic [NUM_AXES-1:0]                 w_ok;
    logic [NUM_AXES-1:0][CELL_BITS-1:0]  w_lo;
    logic [NUM_AXES-1:0][CELL_BITS-1:0]  w_hi;
    logic [NUM_AXES-1:0][CELL_BITS-1:0]  w_out_lo;
    logic [NUM_AXES-1:0][CELL_BITS-1:0]  w_out_hi;
    logic [3*BLOCK_BITS-1:0]             w_linear;
    logic                                w_bad;
    logic                                w_pipe_ready;
    logic                                w_accept;
    t_pipe_ctl                           w_ctl;

    // configuration registers; out-of-range indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells  <= {NUM_AXES{CELL_BITS'(1)}};
            r_blocks <= {NUM_AXES{BLOCK_BITS'(1)}};
            r_start  <= 1'b0;
        end else begin
            r_start <= i_cfg_we;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CELLS_X:  r_cells[0]  <= i_cfg_data[CELL_BITS-1:0];
                    REG_CELLS_Y:  r_cells[1]  <= i_cfg_data[CELL_BITS-1:0];
                    REG_CELLS_Z:  r_cells[2]  <= i_cfg_data[CELL_BITS-1:0];
                    REG_BLOCKS_X: r_blocks[0] <= i_cfg_data[BLOCK_BITS-1:0];
                    REG_BLOCKS_Y: r_blocks[1] <= i_cfg_data[BLOCK_BITS-1:0];
                    REG_BLOCKS_Z: r_blocks[2] <= i_cfg_data[BLOCK_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // nx*ny for the linear index, settled while the dividers run
    always_ff @(posedge i_clk) begin
        r_blocks_xy <= r_blocks[0] * r_blocks[1];
    end

    // input transfer
    assign s_axis_tready = w_pipe_ready & ~(|w_busy) & ~r_start & ~i_cfg_we;
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    assign w_pos[0] = s_axis_tdata[BLOCK_BITS-1:0];
    assign w_pos[1] = s_axis_tdata[2*BLOCK_BITS-1:BLOCK_BITS];
    assign w_pos[2] = s_axis_tdata[3*BLOCK_BITS-1:2*BLOCK_BITS];

    // one lane per axis
    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        bbe_lane #(
            .CELL_BITS  (CELL_BITS),
            .BLOCK_BITS (BLOCK_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_start  (r_start),
            .i_ctl    (w_ctl),
            .i_cells  (r_cells[g]),
            .i_blocks (r_blocks[g]),
            .i_pos    (w_pos[g]),
            .o_busy   (w_busy[g]),
            .o_ok     (w_ok[g]),
            .o_lo     (w_lo[g]),
            .o_hi     (w_hi[g])
        );
    end

    bbe_merge #(
        .CELL_BITS  (CELL_BITS),
        .BLOCK_BITS (BLOCK_BITS)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_out_ready  (m_axis_tready),
        .i_pos_i      (w_pos[0]),
        .i_pos_j      (w_pos[1]),
        .i_pos_k      (w_pos[2]),
        .i_blocks_x   (r_blocks[0]),
        .i_blocks_xy  (r_blocks_xy),
        .i_ok         (w_ok),
        .i_lo         (w_lo),
        .i_hi         (w_hi),
        .o_ctl        (w_ctl),
        .o_pipe_ready (w_pipe_ready),
        .o_valid      (m_axis_tvalid),
        .o_lo         (w_out_lo),
        .o_hi         (w_out_hi),
        .o_linear     (w_linear),
        .o_bad        (w_bad)
    );

    // result packing, first field lowest
    assign m_axis_tdata = OUT_W'({w_linear,
                                 w_out_hi[2], w_out_lo[2],
                                 w_out_hi[1], w_out_lo[1],
                                 w_out_hi[0], w_out_lo[0]});
    assign m_axis_tuser = w_bad;

`ifndef SYNTH
    // no request is taken while a divider is still working
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (w_busy == '0) && !r_start)
        else $error("request taken during divider update");

    // a configuration write closes the input for the next cycle
    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !s_axis_tready)
        else $error("input open right after configuration write");

    // refused requests carry all-zero fields
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[FLD_W-1:0] == '0))
        else $error("refused request with non-zero fields");

    // accepted requests give non-empty ranges
    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            (w_out_hi[0] >= w_out_lo[0]) && (w_out_hi[1] >= w_out_lo[1]) &&
            (w_out_hi[2] >= w_out_lo[2]))
        else $error("block range with last cell below first");
`endif

endmodule
`default_nettype wire

@@ sv/bbe_div.sv @@
// Balanced block extent: restoring divider, one quotient bit per cycle.
// Gives cells / blocks and cells mod blocks for one axis; uses bbe_pkg.
`default_nettype none
module bbe_div
    import bbe_pkg::*;
#(
    parameter int unsigned CELL_BITS  = 16,
    parameter int unsigned BLOCK_BITS = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [CELL_BITS-1:0]  i_dividend,
    input  wire logic [BLOCK_BITS-1:0] i_divisor,
    output logic                       o_busy,
    output logic [CELL_BITS-1:0]       o_quo,
    output logic [BLOCK_BITS-1:0]      o_rem
);

    localparam int unsigned CNT_W = $clog2(CELL_BITS + 1);

    logic [CNT_W-1:0]      r_cnt;
    logic [CELL_BITS-1:0]  r_quo;
    logic [BLOCK_BITS-1:0] r_rem;
    logic [BLOCK_BITS:0]   w_trial;
    logic [BLOCK_BITS+1:0] w_diff;
    logic                  w_ge;

    // shift the next dividend bit into the partial remainder and try a subtract
    assign w_trial = {r_rem, r_quo[CELL_BITS-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, i_divisor};
    assign w_ge    = ~w_diff[BLOCK_BITS+1];

    // step counter; a start restarts the division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(CELL_BITS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // working registers double as the results once the count runs out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[CELL_BITS-2:0], w_ge};
            r_rem <= w_ge ? w_diff[BLOCK_BITS-1:0] : w_trial[BLOCK_BITS-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

@@ sv/bbe_lane.sv @@
// Balanced block extent: one axis lane (divider, product stage, lo/hi adders).
// Depends on bbe_pkg and bbe_div.
`default_nettype none
module bbe_lane
    import bbe_pkg::*;
#(
    parameter int unsigned CELL_BITS  = 16,
    parameter int unsigned BLOCK_BITS = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire t_pipe_ctl             i_ctl,
    input  wire logic [CELL_BITS-1:0]  i_cells,
    input  wire logic [BLOCK_BITS-1:0] i_blocks,
    input  wire logic [BLOCK_BITS-1:0] i_pos,
    output logic                       o_busy,
    output logic                       o_ok,
    output logic [CELL_BITS-1:0]       o_lo,
    output logic [CELL_BITS-1:0]       o_hi
);

    localparam int unsigned W = (CELL_BITS > BLOCK_BITS) ? CELL_BITS : BLOCK_BITS;

    logic [CELL_BITS-1:0]            w_base;
    logic [BLOCK_BITS-1:0]           w_extra;
    logic [CELL_BITS+BLOCK_BITS-1:0] w_prod;
    logic [W-1:0]                    w_cells_w;
    logic [W-1:0]                    w_blocks_w;
    logic                            w_ok;

    logic [CELL_BITS-1:0]  r_prod;
    logic [BLOCK_BITS-1:0] r_pos;
    logic                  r_below;
    logic                  r_ok;

    logic [W-1:0]          w_add;
    logic [CELL_BITS-1:0]  w_lo;

    bbe_div #(
        .CELL_BITS  (CELL_BITS),
        .BLOCK_BITS (BLOCK_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_dividend (i_cells),
        .i_divisor  (i_blocks),
        .o_busy     (o_busy),
        .o_quo      (w_base),
        .o_rem      (w_extra)
    );

    // axis usable and coordinate in range
    assign w_cells_w  = W'(i_cells);
    assign w_blocks_w = W'(i_blocks);
    assign w_ok = (i_blocks != '0) && (w_blocks_w < w_cells_w) && (i_pos < i_blocks);
    assign w_prod = i_pos * w_base;

    // product stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_prod  <= w_prod[CELL_BITS-1:0];
            r_pos   <= i_pos;
            r_below <= (i_pos < w_extra);
            r_ok    <= w_ok;
        end
    end

    // leading blocks carry one extra cell: lo = pos*(base+1), else pos*base + extra
    assign w_add = r_below ? W'(r_pos) : W'(w_extra);
    assign w_lo  = r_prod + w_add[CELL_BITS-1:0];

    assign o_ok = r_ok;
    assign o_lo = w_lo;
    assign o_hi = w_lo + w_base - {{(CELL_BITS-1){1'b0}}, ~r_below};

endmodule
`default_nettype wire

@@ sv/bbe_merge.sv @@
// Balanced block extent: handshake control, linear index and output register.
// Combines the three lane results; depends on bbe_pkg.
`default_nettype none
module bbe_merge
    import bbe_pkg::*;
#(
    parameter int unsigned CELL_BITS  = 16,
    parameter int unsigned BLOCK_BITS = 10
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_accept,
    input  wire logic                                   i_out_ready,
    input  wire logic [BLOCK_BITS-1:0]                  i_pos_i,
    input  wire logic [BLOCK_BITS-1:0]                  i_pos_j,
    input  wire logic [BLOCK_BITS-1:0]                  i_pos_k,
    input  wire logic [BLOCK_BITS-1:0]                  i_blocks_x,
    input  wire logic [2*BLOCK_BITS-1:0]                i_blocks_xy,
    input  wire logic [NUM_AXES-1:0]                    i_ok,
    input  wire logic [NUM_AXES-1:0][CELL_BITS-1:0]     i_lo,
    input  wire logic [NUM_AXES-1:0][CELL_BITS-1:0]     i_hi,
    output t_pipe_ctl                                   o_ctl,
    output logic                                        o_pipe_ready,
    output logic                                        o_valid,
    output logic [NUM_AXES-1:0][CELL_BITS-1:0]          o_lo,
    output logic [NUM_AXES-1:0][CELL_BITS-1:0]          o_hi,
    output logic [3*BLOCK_BITS-1:0]                     o_linear,
    output logic                                        o_bad
);

    localparam int unsigned LIN_W = 3 * BLOCK_BITS;

    logic                  r_v1;
    logic                  r_ov;
    logic                  w_adv2;
    logic [BLOCK_BITS-1:0] r_i;
    logic [LIN_W-1:0]      r_jb;
    logic [LIN_W-1:0]      r_kb;
    logic [3*BLOCK_BITS-1:0] w_kprod;
    logic                  w_good;

    logic [NUM_AXES-1:0][CELL_BITS-1:0] r_lo;
    logic [NUM_AXES-1:0][CELL_BITS-1:0] r_hi;
    logic [LIN_W-1:0]      r_lin;
    logic                  r_bad;

    // stage advance: the output register empties or is taken this cycle
    assign w_adv2       = ~r_ov | i_out_ready;
    assign o_pipe_ready = ~r_v1 | w_adv2;
    assign o_ctl.ld1    = i_accept;
    assign o_ctl.ld2    = r_v1 & w_adv2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_accept) begin
                r_v1 <= 1'b1;
            end else if (w_adv2) begin
                r_v1 <= 1'b0;
            end
            if (o_ctl.ld2) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // linear index partial products
    assign w_kprod = i_pos_k * i_blocks_xy;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_i  <= i_pos_i;
            r_jb <= LIN_W'(i_pos_j * i_blocks_x);
            r_kb <= w_kprod[LIN_W-1:0];
        end
    end

    // output register; a refused request gives all-zero fields
    assign w_good = &i_ok;

    always_ff @(posedge i_clk) begin
        if (o_ctl.ld2) begin
            r_bad <= ~w_good;
            r_lo  <= w_good ? i_lo : '0;
            r_hi  <= w_good ? i_hi : '0;
            r_lin <= w_good ? (LIN_W'(r_i) + r_jb + r_kb) : '0;
        end
    end

    assign o_valid  = r_ov;
    assign o_lo     = r_lo;
    assign o_hi     = r_hi;
    assign o_linear = r_lin;
    assign o_bad    = r_bad;

endmodule
`default_nettype wire
